@@ sv/neighbor_threshold_automaton_rows_defines.svh @@
// assertion macros for the checker file of the row automaton
// no dependencies; take in with an include of the bare file name
`ifndef NEIGHBOR_THRESHOLD_AUTOMATON_ROWS_DEFINES_SVH
`define NEIGHBOR_THRESHOLD_AUTOMATON_ROWS_DEFINES_SVH

// clocked check, quiet while reset is held
`define NTAR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked check that also runs through reset
`define NTAR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ sv/ntar_pkg.sv @@
// shared types and constants of the row-streaming neighbour-threshold automaton
// no dependencies
package ntar_pkg;

    localparam int ROW_CELLS       = 64;
    localparam int ROW_BITS        = 64;
    localparam int NEIGHBOUR_COUNT = 8;
    localparam int CNT_W           = $clog2(NEIGHBOUR_COUNT + 1);
    localparam int WIDTH_W         = 7;
    localparam int BOUND_W         = 4;
    localparam int CFG_IDX_W       = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_COL_SPAN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_BOUND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_BOUND = 2'd2;

    localparam logic [WIDTH_W-1:0] COL_SPAN_RST    = 7'd64;
    localparam logic [BOUND_W-1:0] LOWER_BOUND_RST = 4'd2;
    localparam logic [BOUND_W-1:0] UPPER_BOUND_RST = 4'd3;

    typedef struct packed {
        logic [ROW_BITS-1:0] row_cells;
        logic                last_row;
    } t_in_beat;

    typedef struct packed {
        logic [ROW_BITS-1:0] next_row_cells;
        logic                grid_done;
        logic                last_of_run;
    } t_out_beat;

    // control part of a row job waiting for the lanes
    typedef struct packed {
        logic valid;
        logic done;
        logic last;
    } t_job_ctl;

endpackage

@@ sv/neighbor_threshold_automaton_rows.sv @@
// row-streaming life-like automaton: one row in per cycle unless stalled, next generation one row late
// a result beat goes from its causing row through the job register, then the output register
// throughput: one row per cycle while the output is not stalled; a bottom row after others gives two
// output beats, the second formed from held rows while the input is stalled
// reset: synchronous active low, clears held rows, pending work and restores the registers
module neighbor_threshold_automaton_rows #(
    parameter int P_ROW_CELLS = ntar_pkg::ROW_CELLS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // row input
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  ntar_pkg::t_in_beat             i_in_data,
    // next-generation output
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output ntar_pkg::t_out_beat            o_out_data,
    // register writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ntar_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ntar_pkg::WIDTH_W-1:0]   i_cfg_data
);
    import ntar_pkg::*;

    // configuration registers
    logic [WIDTH_W-1:0]     r_col_span;
    logic [BOUND_W-1:0]     r_lower;
    logic [BOUND_W-1:0]     r_upper;

    logic [P_ROW_CELLS-1:0] w_col_mask;
    logic [P_ROW_CELLS-1:0] w_cur;
    t_job_ctl               w_job;
    logic [P_ROW_CELLS-1:0] w_up, w_mid, w_dn;
    logic [P_ROW_CELLS+1:0] w_up_ext, w_mid_ext, w_dn_ext;
    logic [P_ROW_CELLS-1:0] w_next;
    logic                   w_out_ready;
    logic                   w_job_take;

    // output register
    logic                   r_out_valid;
    t_out_beat              r_out_data;

    // writes always taken; the user must issue them only while the block is idle, the block does not enforce it
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_span <= COL_SPAN_RST;
            r_lower    <= LOWER_BOUND_RST;
            r_upper    <= UPPER_BOUND_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_COL_SPAN:    r_col_span <= i_cfg_data;
                CFG_LOWER_BOUND: r_lower    <= i_cfg_data[BOUND_W-1:0];
                CFG_UPPER_BOUND: r_upper    <= i_cfg_data[BOUND_W-1:0];
                default: ;
            endcase
        end
    end

    // columns in use: below the column span, capped by the lane count
    always_comb begin
        for (int c = 0; c < P_ROW_CELLS; c++) begin
            w_col_mask[c] = (WIDTH_W'(c) < r_col_span);
        end
    end

    // incoming row trimmed to the columns in use before it is stored
    assign w_cur = i_in_data.row_cells[P_ROW_CELLS-1:0] & w_col_mask;

    ntar_window #(
        .P_ROW_CELLS (P_ROW_CELLS)
    ) u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cur      (w_cur),
        .i_last     (i_in_data.last_row),
        .i_job_take (w_job_take),
        .o_in_stall (o_in_stall),
        .o_job      (w_job),
        .o_up       (w_up),
        .o_mid      (w_mid),
        .o_dn       (w_dn)
    );

    // held rows are masked again, the width may have moved since they were stored;
    // a dead column pads each side of the grid
    assign w_up_ext  = {1'b0, w_up  & w_col_mask, 1'b0};
    assign w_mid_ext = {1'b0, w_mid & w_col_mask, 1'b0};
    assign w_dn_ext  = {1'b0, w_dn  & w_col_mask, 1'b0};

    // one lane per column, each sees the three-wide slice centred on its column
    for (genvar c = 0; c < P_ROW_CELLS; c++) begin : g_lane
        ntar_lane u_lane (
            .i_up     (w_up_ext[c+2:c]),
            .i_mid    (w_mid_ext[c+2:c]),
            .i_dn     (w_dn_ext[c+2:c]),
            .i_in_use (w_col_mask[c]),
            .i_lower  (r_lower),
            .i_upper  (r_upper),
            .o_alive  (w_next[c])
        );
    end

    // merge stage: lane bits gathered into the output beat
    assign w_out_ready = !r_out_valid || !i_out_stall;
    assign w_job_take  = w_job.valid && w_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= w_job.valid;
        end
        if (w_job_take) begin
            r_out_data.next_row_cells <= ROW_BITS'(w_next);
            r_out_data.grid_done      <= w_job.done;
            r_out_data.last_of_run    <= w_job.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ sv/ntar_lane.sv @@
// one cell lane: counts the eight neighbours and applies the survival window
// depends on ntar_pkg
module ntar_lane (
    input  logic [2:0]                   i_up,
    input  logic [2:0]                   i_mid,
    input  logic [2:0]                   i_dn,
    input  logic                         i_in_use,
    input  logic [ntar_pkg::BOUND_W-1:0] i_lower,
    input  logic [ntar_pkg::BOUND_W-1:0] i_upper,
    output logic                         o_alive
);
    import ntar_pkg::*;

    logic [NEIGHBOUR_COUNT-1:0] w_nb;
    logic [CNT_W-1:0]           w_cnt;
    logic [BOUND_W-1:0]         w_cnt_ext;

    // own cell (middle of the centre row) is left out
    assign w_nb = {i_up, i_mid[2], i_mid[0], i_dn};

    always_comb begin
        w_cnt = '0;
        for (int k = 0; k < NEIGHBOUR_COUNT; k++) begin
            w_cnt = w_cnt + CNT_W'(w_nb[k]);
        end
    end

    assign w_cnt_ext = BOUND_W'(w_cnt);
    assign o_alive   = i_in_use && (w_cnt_ext >= i_lower) && (w_cnt_ext <= i_upper);

endmodule

@@ sv/ntar_window.sv @@
// row window: holds the two previous rows and forms one row job per cycle while its job slot is free
// depends on ntar_pkg
module ntar_window #(
    parameter int P_ROW_CELLS = ntar_pkg::ROW_CELLS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic [P_ROW_CELLS-1:0] i_cur,
    input  logic                   i_last,
    input  logic                   i_job_take,
    output logic                   o_in_stall,
    output ntar_pkg::t_job_ctl     o_job,
    output logic [P_ROW_CELLS-1:0] o_up,
    output logic [P_ROW_CELLS-1:0] o_mid,
    output logic [P_ROW_CELLS-1:0] o_dn
);
    import ntar_pkg::*;

    logic [P_ROW_CELLS-1:0] r_above, n_above;
    logic [P_ROW_CELLS-1:0] r_middle, n_middle;
    logic                   r_held, n_held;
    logic                   r_pend, n_pend;
    t_job_ctl               r_job, n_job;
    logic [P_ROW_CELLS-1:0] r_up, n_up;
    logic [P_ROW_CELLS-1:0] r_mid, n_mid;
    logic [P_ROW_CELLS-1:0] r_dn, n_dn;
    logic                   w_slot_free;
    logic                   w_accept;

    assign w_slot_free = !r_job.valid || i_job_take;
    assign o_in_stall  = !w_slot_free || r_pend;
    assign w_accept    = i_in_valid && !o_in_stall;

    always_comb begin
        n_above  = r_above;
        n_middle = r_middle;
        n_held   = r_held;
        n_pend   = r_pend;
        n_job    = r_job;
        n_up     = r_up;
        n_mid    = r_mid;
        n_dn     = r_dn;
        if (w_accept) begin
            if (!r_held) begin
                if (i_last) begin
                    // single-row grid
                    n_job = '{valid: 1'b1, done: 1'b1, last: 1'b1};
                    n_up  = '0;
                    n_mid = i_cur;
                    n_dn  = '0;
                end else begin
                    n_job.valid = 1'b0;
                    n_above     = '0;
                    n_middle    = i_cur;
                    n_held      = 1'b1;
                end
            end else begin
                n_job    = '{valid: 1'b1, done: 1'b0, last: !i_last};
                n_up     = r_above;
                n_mid    = r_middle;
                n_dn     = i_cur;
                n_above  = r_middle;
                n_middle = i_cur;
                n_pend   = i_last;
            end
        end else if (r_pend && w_slot_free) begin
            // closing row of the grid, dead row below
            n_job    = '{valid: 1'b1, done: 1'b1, last: 1'b1};
            n_up     = r_above;
            n_mid    = r_middle;
            n_dn     = '0;
            n_pend   = 1'b0;
            n_above  = '0;
            n_middle = '0;
            n_held   = 1'b0;
        end else if (i_job_take) begin
            n_job.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_above  <= '0;
            r_middle <= '0;
            r_held   <= 1'b0;
            r_pend   <= 1'b0;
            r_job    <= '0;
        end else begin
            r_above  <= n_above;
            r_middle <= n_middle;
            r_held   <= n_held;
            r_pend   <= n_pend;
            r_job    <= n_job;
        end
        r_up  <= n_up;
        r_mid <= n_mid;
        r_dn  <= n_dn;
    end

    assign o_job = r_job;
    assign o_up  = r_up;
    assign o_mid = r_mid;
    assign o_dn  = r_dn;

endmodule

@@ sv/ntar_checker.sv @@
// port-level checks of the row automaton, bound onto the top level
// depends on ntar_pkg and neighbor_threshold_automaton_rows_defines.svh
`include "neighbor_threshold_automaton_rows_defines.svh"

module ntar_checker #(
    parameter int P_ROW_CELLS = ntar_pkg::ROW_CELLS
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input ntar_pkg::t_out_beat o_out_data
);
    import ntar_pkg::*;

    logic [ROW_BITS-1:0] w_high_cells;

    // columns beyond the lane count never come alive
    assign w_high_cells = o_out_data.next_row_cells >> P_ROW_CELLS;

    `NTAR_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data), "stalled output beat changed")
    `NTAR_ASSERT(a_done_is_last, o_out_valid && o_out_data.grid_done |-> o_out_data.last_of_run, "grid end not last beat of run")
    `NTAR_ASSERT(a_high_dead, o_out_valid |-> w_high_cells == '0, "cell beyond lane count alive")
    `NTAR_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule

bind neighbor_threshold_automaton_rows ntar_checker #(
    .P_ROW_CELLS (P_ROW_CELLS)
) u_ntar_checker (.*);

@@ sim/testbench.sv @@
// self-checking testbench for the row-streaming neighbour-threshold automaton
// predicts every next-generation row in step with the accepted input rows
// depends on ntar_pkg and neighbor_threshold_automaton_rows
`timescale 1ns / 1ps

module testbench;

    import ntar_pkg::*;

    // run shape
    localparam int          RANDOM_ROWS = 1900;
    localparam int          SETTLE      = 6;       // result beats trail the row through the job and output registers
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int          REPORT_MAX  = 10;

    // register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // receiver stall patterns
    typedef enum logic [1:0] {RX_FLOW, RX_SPARSE, RX_BURSTY, RX_HEAVY} t_rx_mode;

    // block ports, the driven inputs all known from time zero
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in_beat             i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_beat            o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [WIDTH_W-1:0]   i_cfg_data  = '0;

    // predictor copy of the registers and the held rows
    logic [WIDTH_W-1:0]  rule_width;
    logic [BOUND_W-1:0]  rule_lo;
    logic [BOUND_W-1:0]  rule_hi;
    logic [ROW_BITS-1:0] held_above;
    logic [ROW_BITS-1:0] held_middle;
    logic                grid_open;

    // next-generation rows still owed by the block, oldest first
    t_out_beat pending_rows[$];

    // bookkeeping
    int unsigned cycle_count   = 0;
    int unsigned fault_count   = 0;
    int unsigned rows_in       = 0;
    int unsigned grids_in      = 0;
    int unsigned beats_checked = 0;
    int unsigned reg_writes    = 0;
    int unsigned rule_sets     = 0;

    // idling controls
    bit          tx_idle   = 1'b0;   // sender bursts and gaps
    int unsigned burst_left = 0;
    logic        rx_auto   = 1'b0;   // receiver stall pattern on or off
    t_rx_mode    rx_mode   = RX_FLOW;
    int unsigned rx_mode_left = 0;
    int unsigned rx_run_left  = 0;
    logic        rx_hold   = 1'b0;

    neighbor_threshold_automaton_rows i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic int cols_used();
        int w;
        w = int'(rule_width);
        if (w > ROW_CELLS) w = ROW_CELLS;
        return w;
    endfunction

    // cells off either side of the used columns read as dead
    function automatic int cell_at(input logic [ROW_BITS-1:0] row, input int col,
                                   input int ncols);
        if (col < 0 || col >= ncols) return 0;
        return int'(row[col]);
    endfunction

    function automatic logic [ROW_BITS-1:0] next_gen(input logic [ROW_BITS-1:0] up,
                                                     input logic [ROW_BITS-1:0] mid,
                                                     input logic [ROW_BITS-1:0] down);
        int                  ncols;
        int                  live;
        logic [ROW_BITS-1:0] gen;
        ncols = cols_used();
        gen   = '0;
        for (int col = 0; col < ncols; col++) begin
            live = 0;
            // own cell left out, only the eight around it count
            for (int dc = -1; dc <= 1; dc++) begin
                live += cell_at(up, col + dc, ncols) + cell_at(down, col + dc, ncols);
                if (dc != 0) live += cell_at(mid, col + dc, ncols);
            end
            if (live >= int'(rule_lo) && live <= int'(rule_hi)) gen[col] = 1'b1;
        end
        return gen;
    endfunction

    function automatic void owe_row(input logic [ROW_BITS-1:0] cells, input logic done,
                                    input logic last);
        t_out_beat beat;
        beat.next_row_cells = cells;
        beat.grid_done      = done;
        beat.last_of_run    = last;
        pending_rows.push_back(beat);
    endfunction

    function automatic void clear_held();
        held_above  = '0;
        held_middle = '0;
        grid_open   = 1'b0;
    endfunction

    function automatic void predict_next_rows(input t_in_beat beat);
        logic [ROW_BITS-1:0] cur;
        logic [ROW_BITS-1:0] mask;
        mask = (cols_used() >= ROW_BITS) ? '1 : ((64'd1 << cols_used()) - 64'd1);
        cur  = beat.row_cells & mask;
        rows_in++;
        if (beat.last_row) grids_in++;
        if (!grid_open) begin
            if (beat.last_row) begin
                // grid of one row: dead rows on both sides
                owe_row(next_gen('0, cur, '0), 1'b1, 1'b1);
                clear_held();
            end else begin
                // top row is only stored
                held_above  = '0;
                held_middle = cur;
                grid_open   = 1'b1;
            end
        end else begin
            owe_row(next_gen(held_above, held_middle, cur), 1'b0, !beat.last_row);
            held_above  = held_middle;
            held_middle = cur;
            if (beat.last_row) begin
                // bottom row closes the grid with a dead row below
                owe_row(next_gen(held_above, held_middle, '0), 1'b1, 1'b1);
                clear_held();
            end
        end
    endfunction

    function automatic void report_fault(input string what);
        fault_count++;
        if (fault_count <= REPORT_MAX) $display("[%0t] %s", $time, what);
    endfunction

    function automatic void check_beat(input t_out_beat got);
        t_out_beat want;
        if (pending_rows.size() == 0) begin
            report_fault($sformatf("result beat with nothing owed: row %h done %b last %b",
                                   got.next_row_cells, got.grid_done, got.last_of_run));
            return;
        end
        want = pending_rows.pop_front();
        beats_checked++;
        if (got.next_row_cells !== want.next_row_cells || got.grid_done !== want.grid_done ||
            got.last_of_run !== want.last_of_run) begin
            report_fault($sformatf(
                "row mismatch: expected %h done %b last %b, got %h done %b last %b",
                want.next_row_cells, want.grid_done, want.last_of_run,
                got.next_row_cells, got.grid_done, got.last_of_run));
        end
    endfunction

    // one monitor for register writes, row beats and result beats, all sampled
    // on the pre-edge values
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rule_width = COL_SPAN_RST;
            rule_lo    = LOWER_BOUND_RST;
            rule_hi    = UPPER_BOUND_RST;
            clear_held();
            pending_rows.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                reg_writes++;
                case (i_cfg_index)
                    CFG_COL_SPAN: begin
                        rule_width = i_cfg_data;
                    end
                    CFG_LOWER_BOUND: begin
                        rule_lo = i_cfg_data[BOUND_W-1:0];
                    end
                    CFG_UPPER_BOUND: begin
                        rule_hi = i_cfg_data[BOUND_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && !o_in_stall) predict_next_rows(i_in_data);
            if (o_out_valid && !i_out_stall) check_beat(o_out_data);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d result beats still owed",
                     cycle_count, pending_rows.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver stall, switching between its own patterns
    always @(posedge i_clk) begin
        if (!rx_auto) begin
            rx_run_left = 0;
            i_out_stall <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = t_rx_mode'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(16, 160);
            end else begin
                rx_mode_left--;
            end
            case (rx_mode)
                RX_FLOW: begin
                    i_out_stall <= 1'b0;
                end
                RX_SPARSE: begin
                    i_out_stall <= ($urandom_range(0, 3) == 0);
                end
                RX_HEAVY: begin
                    i_out_stall <= ($urandom_range(0, 3) != 0);
                end
                default: begin
                    // alternating runs of stall and flow
                    if (rx_run_left == 0) begin
                        rx_hold     = ~rx_hold;
                        rx_run_left = $urandom_range(1, 8);
                    end
                    rx_run_left--;
                    i_out_stall <= rx_hold;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // one row beat; valid stays high into the next beat unless a gap is drawn
    task automatic send_row(input logic [ROW_BITS-1:0] cells, input logic last);
        int unsigned gap;
        if (tx_idle) begin
            if (burst_left == 0) begin
                gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20)
                                                         : $urandom_range(1, 6);
                burst_left = $urandom_range(1, 24);
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                burst_left--;
            end
        end
        i_in_valid          <= 1'b1;
        i_in_data.row_cells <= cells;
        i_in_data.last_row  <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // input quiet, every owed row back, then a little more for a stored top row
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        // first let the monitor book the last accepted row
        @(posedge i_clk);
        while (pending_rows.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WIDTH_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // bounds carry junk in the unused upper data bits
    task automatic set_rules(input logic [WIDTH_W-1:0] width, input logic [BOUND_W-1:0] lo,
                             input logic [BOUND_W-1:0] hi);
        wait_idle();
        write_reg(CFG_COL_SPAN, width);
        write_reg(CFG_LOWER_BOUND, {3'($urandom_range(0, 7)), lo});
        write_reg(CFG_UPPER_BOUND, {3'($urandom_range(0, 7)), hi});
        rule_sets++;
    endtask

    function automatic logic [ROW_BITS-1:0] rand_row();
        case ($urandom_range(0, 9))
            0:       return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            1, 2:    return {$urandom, $urandom} & {$urandom, $urandom};
            3:       return {$urandom, $urandom} | {$urandom, $urandom};
            4:       return ($urandom_range(0, 1) == 0) ? '0 : '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset rules: survival-style bounds over the full width
    task automatic test_reset_rules();
        // vertical blinker at column 5
        send_row(64'h0000_0000_0000_0020, 1'b0);
        send_row(64'h0000_0000_0000_0020, 1'b0);
        send_row(64'h0000_0000_0000_0020, 1'b1);
        // single-row grids, full and empty
        send_row('1, 1'b1);
        send_row('0, 1'b1);
        // two-row grid with life hard against both edges
        send_row(64'hC000_0000_0000_0003, 1'b0);
        send_row('1, 1'b1);
    endtask

    task automatic test_width_extremes();
        wait_idle();
        write_reg(CFG_UNUSED, '1);
        set_rules(7'd1, 4'd0, 4'd8);
        send_row('1, 1'b0);
        send_row('1, 1'b0);
        send_row('1, 1'b1);
        // no columns in use at all
        set_rules(7'd0, 4'd0, 4'd8);
        send_row('1, 1'b0);
        send_row('1, 1'b1);
        // width above the row is clamped
        set_rules(7'd127, 4'd1, 4'd3);
        send_row(64'h8000_0000_0000_0001, 1'b0);
        send_row(64'h4000_0000_0000_0002, 1'b1);
        set_rules(7'd3, 4'd0, 4'd2);
        send_row('1, 1'b1);
    endtask

    task automatic test_bound_extremes();
        // every cell alive whatever its neighbours
        set_rules(7'd64, 4'd0, 4'd8);
        send_row(rand_row(), 1'b0);
        send_row(rand_row(), 1'b1);
        // only fully surrounded cells
        set_rules(7'd64, 4'd8, 4'd8);
        send_row('1, 1'b0);
        send_row('1, 1'b0);
        send_row('1, 1'b1);
        // lower above upper: nothing survives
        set_rules(7'd64, 4'd5, 4'd2);
        send_row('1, 1'b0);
        send_row(64'h5555_5555_5555_5555, 1'b1);
        // bounds beyond eight, and only isolated cells
        set_rules(7'd64, 4'd15, 4'd15);
        send_row('1, 1'b1);
        set_rules(7'd64, 4'd0, 4'd0);
        send_row(64'h0100_0000_8000_0001, 1'b1);
    endtask

    // width narrowed while the top row is held at full width
    task automatic test_width_mid_grid();
        set_rules(7'd64, 4'd2, 4'd3);
        send_row('1, 1'b0);
        wait_idle();
        write_reg(CFG_COL_SPAN, 7'd10);
        send_row('1, 1'b0);
        send_row(64'hFFFF_0000_0000_03FF, 1'b1);
    endtask

    // random rules per phase, random grids within, idling varied per phase
    task automatic test_random_grids();
        int unsigned         random_rows;
        int unsigned         phase_rows;
        int unsigned         target;
        int unsigned         height;
        logic [WIDTH_W-1:0]  width;
        logic [BOUND_W-1:0]  lo;
        logic [BOUND_W-1:0]  hi;
        random_rows = 0;
        while (random_rows < RANDOM_ROWS) begin
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 7))
                    0:       width = 7'd0;
                    1:       width = 7'd1;
                    2:       width = 7'd2;
                    3:       width = 7'd3;
                    4:       width = 7'd63;
                    5:       width = 7'd65;
                    6:       width = 7'd127;
                    default: width = 7'd64;
                endcase
            end else begin
                width = 7'($urandom_range(1, 64));
            end
            if ($urandom_range(0, 4) == 0) begin
                lo = 4'($urandom_range(0, 15));
                hi = 4'($urandom_range(0, 15));
            end else begin
                lo = 4'($urandom_range(0, 4));
                hi = lo + 4'($urandom_range(0, 3));
            end
            set_rules(width, lo, hi);
            // quarter of phases run flat out on both sides
            case ($urandom_range(0, 3))
                0: begin tx_idle = 1'b0; rx_auto <= 1'b0; end
                1: begin tx_idle = 1'b1; rx_auto <= 1'b0; end
                2: begin tx_idle = 1'b0; rx_auto <= 1'b1; end
                default: begin tx_idle = 1'b1; rx_auto <= 1'b1; end
            endcase
            target     = $urandom_range(40, 160);
            phase_rows = 0;
            while (phase_rows < target) begin
                case ($urandom_range(0, 9))
                    0:       height = 1;
                    1:       height = $urandom_range(20, 40);
                    default: height = $urandom_range(2, 10);
                endcase
                for (int r = 0; r < height; r++) send_row(rand_row(), (r == height - 1));
                phase_rows += height;
            end
            random_rows += phase_rows;
        end
        tx_idle = 1'b0;
        rx_auto <= 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_rules();
        test_width_extremes();
        test_bound_extremes();
        test_width_mid_grid();
        test_random_grids();

        wait_idle();
        if (pending_rows.size() != 0) begin
            report_fault($sformatf("%0d owed result beats never arrived", pending_rows.size()));
        end

        $display("covered %0d rows in %0d grids, %0d result beats checked", rows_in, grids_in,
                 beats_checked);
        $display("%0d register writes over %0d rule settings, %0d faults", reg_writes,
                 rule_sets, fault_count);
        if (fault_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
